FILE: design/hsa_pkg.sv
// Shared constants and types of the HSL saturation adjustment block.
package hsa_pkg;

  localparam int FRAC_BITS = 16;
  // Width of the saturation value, of the factors and of the config quotient.
  localparam int QW        = FRAC_BITS + 8;
  // Dividend width of the factor division 2^(2F) / S.
  localparam int D2W       = 2 * FRAC_BITS + 1;
  // Width of one channel's signed sum before the final shift.
  localparam int NW        = QW + 12;
  localparam int CW        = QW + 8;
  localparam int CNT_W     = $clog2(QW);

  localparam int PCT_SCALE = 100;
  localparam int BYTE_MAX  = 255;

  typedef struct packed {
    logic [2:0][7:0] ch;    // blue in [0], green in [1], red in [2]
    logic [8:0]      sum;
    logic            gray;
  } pix_t;

endpackage

FILE: design/hsa_cfg.sv
// Percent register and serial division of the percent-only factor.
module hsa_cfg import hsa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data,
  output logic signed [7:0]   pct,
  output logic [QW-1:0]       fac,
  output logic                busy
);

  logic [6:0]       rem;
  logic [6:0]       dv;
  logic [QW-1:0]    num;
  logic [CNT_W-1:0] cnt;
  logic [7:0]       t;
  logic             ge;
  logic [QW-1:0]    num_init;
  logic [6:0]       dv_init;
  logic signed [8:0] low_sum;

  assign cfg_ready = !busy;
  assign fac       = num;

  // Percent p from 0 to 99: p / (100 - p); from 100 up, p / 1. Negative
  // percent: (100 + p) / 100, or zero below minus one hundred.
  always_comb begin
    low_sum = 9'(PCT_SCALE) + {cfg_data[7], cfg_data};
    if (!cfg_data[7]) begin
      num_init = QW'({cfg_data[6:0], {FRAC_BITS{1'b0}}});
      dv_init  = (cfg_data[6:0] < 7'(PCT_SCALE)) ? 7'(7'(PCT_SCALE) - cfg_data[6:0]) : 7'd1;
    end else begin
      num_init = low_sum[8] ? '0 : QW'({low_sum[7:0], {FRAC_BITS{1'b0}}});
      dv_init  = 7'(PCT_SCALE);
    end
    t  = {rem, num[QW-1]};
    ge = (t >= {1'b0, dv});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pct  <= '0;
      num  <= '0;
      busy <= 1'b0;
      cnt  <= '0;
      rem  <= '0;
      dv   <= 7'd1;
    end else if (cfg_valid && cfg_ready) begin
      pct  <= cfg_data;
      num  <= num_init;
      dv   <= dv_init;
      rem  <= '0;
      cnt  <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      rem <= ge ? 7'(t - {1'b0, dv}) : t[6:0];
      num <= {num[QW-2:0], ge};
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(QW - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

FILE: design/hsl_saturation_adjust.sv
// HSL saturation adjustment of a BGR pixel stream, one result per pixel.
// It takes one pixel per clock while the skid stage is empty and the config
// divider is idle, through an input register, a 24-stage bit-per-stage
// divider for the saturation, a 33-stage divider for the factor 1/S - 1,
// factor selection, the channel multiply, and the clamping output register
// with a skid stage behind it. While a percent write is busy, a serial
// divider forms the percent-only factor and neither port takes a request.
module hsl_saturation_adjust import hsa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // blue_in, green_in, red_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // blue_out, green_out, red_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data        // saturation_percent
);

  logic signed [7:0] pct;
  logic [QW-1:0]     cfg_fac;
  logic              busy;
  logic              adv;
  logic              sk_full;
  logic [23:0]       sk_data;

  hsa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .pct       (pct),
    .fac       (cfg_fac),
    .busy      (busy)
  );

  assign adv           = !sk_full;
  assign s_axis_tready = adv && !busy;

  // Input stage: channel extremes, sum and the saturation denominator.
  pix_t             in_px;
  logic [7:0]       mx, mn, in_den;
  logic [8:0]       tmp9;

  always_comb begin
    in_px.ch[0] = s_axis_tdata[7:0];
    in_px.ch[1] = s_axis_tdata[15:8];
    in_px.ch[2] = s_axis_tdata[23:16];
    mx = in_px.ch[0];
    mn = in_px.ch[0];
    for (int k = 1; k < 3; k++) begin
      if (in_px.ch[k] > mx) mx = in_px.ch[k];
      if (in_px.ch[k] < mn) mn = in_px.ch[k];
    end
    in_px.sum  = {1'b0, mx} + {1'b0, mn};
    in_px.gray = (mx == mn);
    tmp9       = 9'(2 * BYTE_MAX) - in_px.sum;
    in_den     = (in_px.sum < 9'(BYTE_MAX)) ? in_px.sum[7:0] : tmp9[7:0];
  end

  // Saturation divider: S = (delta << F) / den, one quotient bit per stage.
  logic          d1_v   [0:QW];
  pix_t          d1_px  [0:QW];
  logic [7:0]    d1_rem [0:QW];
  logic [QW-1:0] d1_num [0:QW];
  logic [7:0]    d1_den [0:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_v[0] <= 1'b0;
    end else if (adv) begin
      d1_v[0] <= s_axis_tvalid && s_axis_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_px[0]  <= in_px;
      d1_rem[0] <= '0;
      d1_num[0] <= QW'({8'(mx - mn), {FRAC_BITS{1'b0}}});
      d1_den[0] <= in_den;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_div1
    logic [8:0] t;
    logic       ge;
    always_comb begin
      t  = {d1_rem[i], d1_num[i][QW-1]};
      ge = (t >= {1'b0, d1_den[i]});
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        d1_v[i+1] <= 1'b0;
      end else if (adv) begin
        d1_v[i+1] <= d1_v[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        d1_px[i+1]  <= d1_px[i];
        d1_den[i+1] <= d1_den[i];
        d1_rem[i+1] <= ge ? 8'(t - {1'b0, d1_den[i]}) : t[7:0];
        d1_num[i+1] <= {d1_num[i][QW-2:0], ge};
      end
    end
  end

  // Factor divider: 2^(2F) / S, with the saturation test riding alongside.
  logic           d2_v    [0:D2W];
  pix_t           d2_px   [0:D2W];
  logic           d2_cond [0:D2W];
  logic [QW-1:0]  d2_s    [0:D2W];
  logic [QW-1:0]  d2_rem  [0:D2W];
  logic [D2W-1:0] d2_num  [0:D2W];
  logic [CW-1:0]  lhs;

  always_comb begin
    lhs = CW'({pct[6:0], {FRAC_BITS{1'b0}}}) + CW'(d1_num[QW]) * CW'(PCT_SCALE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d2_v[0] <= 1'b0;
    end else if (adv) begin
      d2_v[0] <= d1_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_px[0]   <= d1_px[QW];
      d2_cond[0] <= (lhs >= (CW'(PCT_SCALE) << FRAC_BITS));
      d2_s[0]    <= d1_num[QW];
      d2_rem[0]  <= '0;
      d2_num[0]  <= D2W'(1) << (2 * FRAC_BITS);
    end
  end

  for (genvar i = 0; i < D2W; i++) begin : g_div2
    logic [QW:0] t;
    logic        ge;
    always_comb begin
      t  = {d2_rem[i], d2_num[i][D2W-1]};
      ge = (t >= {1'b0, d2_s[i]});
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        d2_v[i+1] <= 1'b0;
      end else if (adv) begin
        d2_v[i+1] <= d2_v[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        d2_px[i+1]   <= d2_px[i];
        d2_cond[i+1] <= d2_cond[i];
        d2_s[i+1]    <= d2_s[i];
        d2_rem[i+1]  <= ge ? QW'(t - {1'b0, d2_s[i]}) : t[QW-1:0];
        d2_num[i+1]  <= {d2_num[i][D2W-2:0], ge};
      end
    end
  end

  // Factor selection, channel offsets from lightness and the base terms.
  logic [D2W-1:0]          q2;
  logic [QW-1:0]           fac_sel;
  logic                    e_v;
  pix_t                    e_px;
  logic [QW-1:0]           e_fac;
  logic [2:0][9:0]         e_diff;
  logic [2:0][NW-1:0]      e_base;
  logic [2:0][9:0]         diff_c;
  logic [2:0][NW-1:0]      base_c;

  always_comb begin
    q2 = d2_num[D2W];
    if (pct[7] || !d2_cond[D2W]) begin
      fac_sel = cfg_fac;
    end else if (q2 < (D2W'(1) << FRAC_BITS)) begin
      fac_sel = '0;
    end else if ((q2 - (D2W'(1) << FRAC_BITS)) > D2W'({QW{1'b1}})) begin
      fac_sel = '1;
    end else begin
      fac_sel = QW'(q2 - (D2W'(1) << FRAC_BITS));
    end
    for (int k = 0; k < 3; k++) begin
      diff_c[k] = {1'b0, d2_px[D2W].ch[k], 1'b0} - {1'b0, d2_px[D2W].sum};
      base_c[k] = pct[7] ? NW'({d2_px[D2W].sum, {FRAC_BITS{1'b0}}})
                         : NW'({d2_px[D2W].ch[k], {(FRAC_BITS + 1){1'b0}}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (adv) begin
      e_v <= d2_v[D2W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_px   <= d2_px[D2W];
      e_fac  <= fac_sel;
      e_diff <= diff_c;
      e_base <= base_c;
    end
  end

  // Channel multiply.
  logic                    m_v;
  pix_t                    m_px;
  logic [2:0][NW-1:0]      m_base;
  logic [2:0][NW-1:0]      m_prod;
  logic [2:0][NW-1:0]      prod_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_c[k] = NW'(NW'($signed(e_diff[k])) * NW'($signed({1'b0, e_fac})));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (adv) begin
      m_v <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_px   <= e_px;
      m_base <= e_base;
      m_prod <= prod_c;
    end
  end

  // Final sum, truncation and clamping; gray pixels pass unchanged.
  logic [23:0]        res;
  logic [NW-1:0]      tot;
  logic [NW-1:0]      shv;

  always_comb begin
    res = '0;
    tot = '0;
    shv = '0;
    for (int k = 0; k < 3; k++) begin
      tot = m_base[k] + m_prod[k];
      shv = tot >> (FRAC_BITS + 1);
      if (m_px.gray) begin
        res[8*k +: 8] = m_px.ch[k];
      end else if (tot[NW-1] || tot == '0) begin
        res[8*k +: 8] = 8'd0;
      end else if (shv > NW'(BYTE_MAX)) begin
        res[8*k +: 8] = 8'(BYTE_MAX);
      end else begin
        res[8*k +: 8] = shv[7:0];
      end
    end
  end

  // Output register with a skid stage; the pipeline halts while the skid stage holds a result.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      sk_full       <= 1'b0;
    end else if (sk_full) begin
      if (m_axis_tready) begin
        m_axis_tdata <= sk_data;
        sk_full      <= 1'b0;
      end
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= m_v;
      m_axis_tdata  <= res;
    end else if (m_v) begin
      sk_full <= 1'b1;
      sk_data <= res;
    end
  end

  a_skid_has_out: assert property (@(posedge clk) disable iff (rst)
    sk_full |-> m_axis_tvalid)
    else $error("skid stage holds a result while the output is empty");

  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    busy |-> (!s_axis_tready && !cfg_ready))
    else $error("request taken while the factor is being computed");

  a_skid_catch: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready && !sk_full && m_v) |=> sk_full)
    else $error("result from the pipeline lost while the output stalled");

endmodule

FILE: test/hsl_saturation_adjust_tb.sv
// Self-checking testbench for the HSL saturation adjustment pixel stream.
`timescale 1ns / 1ps

module hsl_saturation_adjust_tb;
  import hsa_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } bgr_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // blue_in, green_in, red_in
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // blue_out, green_out, red_out
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;       // saturation_percent

  hsl_saturation_adjust DUT (.*);

  localparam int LATENCY   = 80;
  localparam int MAX_CYCLE = 400000;

  int          pct_model;
  bgr_t        pixel_q[$];
  int          send_idle;
  int          recv_idle;
  bit          hold_recv;
  int          hold_cycles;
  int          fail_count;
  longint      cycle_count = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("hsl_saturation_adjust_tb failed");
      $finish;
    end
  end

  function automatic logic [7:0] clamp_byte(longint num);
    longint v;
    if (num <= 0) return 8'd0;
    v = num >>> (FRAC_BITS + 1);
    if (v > BYTE_MAX) return 8'd255;
    return v[7:0];
  endfunction

  // Works out the adjusted pixel for the current percent setting.
  function automatic bgr_t adjust_pixel(bgr_t px);
    longint c[3];
    longint mx, mn, sum, delta, den, s, f, g;
    longint one, fmax, p;
    logic [7:0] r[3];
    c[0] = px.blue;
    c[1] = px.green;
    c[2] = px.red;
    one  = longint'(1) << FRAC_BITS;
    fmax = (longint'(1) << (FRAC_BITS + 8)) - 1;
    p    = pct_model;
    mx   = c[0];
    mn   = c[0];
    for (int k = 1; k < 3; k++) begin
      if (c[k] > mx) mx = c[k];
      if (c[k] < mn) mn = c[k];
    end
    delta = mx - mn;
    sum   = mx + mn;
    if (delta == 0) return px;
    den = (sum < BYTE_MAX) ? sum : (2 * BYTE_MAX - sum);
    if (den <= 0) den = 1;
    if (p >= 0) begin
      s = (delta << FRAC_BITS) / den;
      if (p * one + PCT_SCALE * s >= PCT_SCALE * one) begin
        if (s == 0) f = fmax;
        else f = (longint'(1) << (2 * FRAC_BITS)) / s - one;
      end else begin
        f = (p * one) / (PCT_SCALE - p);
      end
      if (f > fmax) f = fmax;
      if (f < 0) f = 0;
      for (int k = 0; k < 3; k++)
        r[k] = clamp_byte(c[k] * 2 * one + (2 * c[k] - sum) * f);
    end else begin
      g = 0;
      if (p >= -PCT_SCALE) g = ((PCT_SCALE + p) * one) / PCT_SCALE;
      for (int k = 0; k < 3; k++)
        r[k] = clamp_byte(sum * one + (2 * c[k] - sum) * g);
    end
    return '{red: r[2], green: r[1], blue: r[0]};
  endfunction

  // Result checker.
  always @(posedge clk) begin
    bgr_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pixel_q.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pixel_q.pop_front();
        if (got.blue != want.blue) begin
          $error("blue_out expected %0d actual %0d", want.blue, got.blue);
          fail_count++;
        end
        if (got.green != want.green) begin
          $error("green_out expected %0d actual %0d", want.green, got.green);
          fail_count++;
        end
        if (got.red != want.red) begin
          $error("red_out expected %0d actual %0d", want.red, got.red);
          fail_count++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (hold_recv) begin
      m_axis_tready <= 1'b0;
      hold_recv <= 1'b0;
      hold_cycles <= 300;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // The valid line stays high after a request is taken, so that requests
  // can follow each other without a gap; idling or draining drops it.
  task automatic send_pixel(bgr_t px);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk); while (!s_axis_tready);
    pixel_q.push_back(adjust_pixel(px));
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_percent(int p);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= 8'(p);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pct_model = p;
  endtask

  function automatic bgr_t rand_pixel();
    return bgr_t'(24'($urandom_range(24'hFFFFFF)));
  endfunction

  task automatic test_directed;
    int pcts[6] = '{0, 100, -100, 50, -37, 1};
    bgr_t fixed_px[8] = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000,
                          24'h00FF00, 24'h0000FF, 24'hFE0102, 24'h7F8081};
    foreach (pcts[i]) begin
      write_percent(pcts[i]);
      foreach (fixed_px[j]) send_pixel(fixed_px[j]);
    end
  endtask

  // Register values outside -100..100 take their own branches in the block.
  task automatic test_out_of_range_percent;
    write_percent(127);
    repeat (10) send_pixel(rand_pixel());
    write_percent(-128);
    repeat (10) send_pixel(rand_pixel());
    write_percent(-101);
    repeat (10) send_pixel(rand_pixel());
  endtask

  task automatic test_random(int phase_items);
    for (int n = 0; n < phase_items; n++) begin
      if (n % 150 == 0) begin
        case ($urandom_range(5))
          0: write_percent(100);
          1: write_percent(-100);
          2: write_percent(0);
          default: write_percent($urandom_range(200) - 100);
        endcase
      end
      send_pixel(rand_pixel());
    end
  endtask

  task automatic test_backpressure;
    hold_recv <= 1'b1;
    repeat (150) send_pixel(rand_pixel());
    // Sender pauses until every request has come back.
    drain();
    repeat (20) send_pixel(rand_pixel());
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    send_idle     = 0;
    recv_idle     = 0;
    hold_recv     = 1'b0;
    hold_cycles   = 0;
    fail_count    = 0;
    pct_model     = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_out_of_range_percent();
    send_idle = 33;
    recv_idle = 59;
    test_random(400);
    send_idle = 59;
    recv_idle = 33;
    test_random(400);
    send_idle = 0;
    recv_idle = 0;
    test_random(400);
    test_backpressure();

    drain();
    if (fail_count == 0)
      $display("hsl_saturation_adjust_tb passed");
    else
      $display("hsl_saturation_adjust_tb failed");
    $finish;
  end

endmodule

FILE: files.f
design/hsa_pkg.sv
design/hsa_cfg.sv
design/hsl_saturation_adjust.sv
test/hsl_saturation_adjust_tb.sv
